[hdl/cvbc_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and register codes for the byte cipher
// no dependencies

package cvbc_pkg;

  localparam int unsigned KeystreamLength = 32;
  localparam int unsigned PosW = (KeystreamLength > 1) ? $clog2(KeystreamLength) : 1;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [KeyW-1:0] LcgMul = 32'd214013;
  localparam logic [KeyW-1:0] LcgAdd = 32'd2531011;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxKey    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMethod = 2'd1;

  typedef enum logic {
    MethodCaesar   = 1'b0,
    MethodVigenere = 1'b1
  } method_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    method_e         method;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             encrypt;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] result_byte;
    logic             result_last;
  } result_t;

endpackage

[hdl/cvbc_if.sv]
`timescale 1ns / 1ps
// handshake channel interfaces: input items, result items, register writes
// depends on cvbc_pkg

interface cvbc_item_if;
  import cvbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             encrypt;
  logic             last;
  modport source (output valid, data_byte, encrypt, last, input ready);
  modport sink   (input valid, data_byte, encrypt, last, output ready);
endinterface

interface cvbc_result_if;
  import cvbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] result_byte;
  logic             result_last;
  modport source (output valid, result_byte, result_last, input ready);
  modport sink   (input valid, result_byte, result_last, output ready);
endinterface

interface cvbc_cfg_if;
  import cvbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [KeyW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/cvbc_cfg_regs.sv]
`timescale 1ns / 1ps
// key and method registers behind the write channel
// depends on cvbc_pkg and cvbc_cfg_if

module cvbc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  cvbc_cfg_if.sink       cfg_i,
  output cvbc_pkg::cfg_t cfg_o
);
  import cvbc_pkg::*;

  logic [KeyW-1:0] key_q, key_d;
  method_e         method_q, method_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_d    = key_q;
    method_d = method_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgIdxKey:    key_d    = cfg_i.data;
        CfgIdxMethod: method_d = method_e'(cfg_i.data[0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      method_q <= MethodCaesar;
    end else begin
      key_q    <= key_d;
      method_q <= method_d;
    end
  end

  assign cfg_o.key    = key_q;
  assign cfg_o.method = method_q;

endmodule

[hdl/cvbc_cipher_stage.sv]
`timescale 1ns / 1ps
// keystream state (lcg value, position, terminator flag) and the byte transform
// depends on cvbc_pkg

module cvbc_cipher_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  cvbc_pkg::item_t   item_i,
  input  cvbc_pkg::cfg_t    cfg_i,
  output cvbc_pkg::result_t result_o
);
  import cvbc_pkg::*;

  logic [KeyW-1:0]  seed_q, seed_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             term_q, term_d;
  logic             term_now;
  logic [KeyW-1:0]  base, lcg_next;
  logic [ByteW-1:0] k;

  assign term_now = term_q || (item_i.data_byte == '0);
  // position zero restarts the keystream from the key
  assign base     = (pos_q == '0) ? cfg_i.key : seed_q;
  assign lcg_next = base * LcgMul + LcgAdd;

  always_comb begin
    k = (cfg_i.method == MethodCaesar) ? cfg_i.key[ByteW-1:0] : lcg_next[23:16];
    result_o.result_last = item_i.last;
    if (term_now) begin
      result_o.result_byte = item_i.data_byte;
    end else if (item_i.encrypt) begin
      result_o.result_byte = item_i.data_byte + k;
    end else begin
      result_o.result_byte = item_i.data_byte - k;
    end
  end

  always_comb begin
    seed_d = seed_q;
    pos_d  = pos_q;
    term_d = term_q;
    if (go_i) begin
      if (!term_now) begin
        seed_d = lcg_next;
        pos_d  = (pos_q == PosW'(KeystreamLength - 1)) ? '0 : pos_q + 1'b1;
      end
      term_d = term_now;
      if (item_i.last) begin
        term_d = 1'b0;
        pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      pos_q  <= '0;
      term_q <= 1'b0;
    end else begin
      seed_q <= seed_d;
      pos_q  <= pos_d;
      term_q <= term_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.last |=> (pos_q == '0) && !term_q)
    else $error("message end did not restart keystream");

  a_zero_terminates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && !item_i.last && (item_i.data_byte == '0) |=> term_q)
    else $error("zero byte did not terminate message");

  a_term_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && term_q && !item_i.last |=> $stable(seed_q) && $stable(pos_q))
    else $error("keystream moved after terminator");

endmodule

[hdl/caesar_vigenere_byte_cipher.sv]
`timescale 1ns / 1ps
// top level of the byte cipher: input register, cipher stage, result register
// depends on cvbc_pkg, cvbc_if, cvbc_cfg_regs, cvbc_cipher_stage
//
//   channel  dir  payload                         handshake
//   in_i     in   data_byte, encrypt, last        valid/ready
//   out_o    out  result_byte, result_last        valid/ready
//   cfg_i    in   index, data                     valid/ready (ready always high)
//
// one word per cycle sustained while out_o is not stalled; a word passes the input register, then the result register
// the lcg step (32x18 constant multiply and add) sits between input and result registers
// reset clears the key, method, keystream state and both valid flags
// a stalled out_o holds the result word; in_i still takes one word into the input register

module caesar_vigenere_byte_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  cvbc_item_if.sink     in_i,
  cvbc_result_if.source out_o,
  cvbc_cfg_if.sink      cfg_i
);
  import cvbc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res, res_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  cvbc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  cvbc_cipher_stage u_cipher_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.encrypt   <= in_i.encrypt;
      item_q.last      <= in_i.last;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_byte = res_q.result_byte;
  assign out_o.result_last = res_q.result_last;

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result word appeared without a processed item");

endmodule
